// File: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table: operation and status codes,
// field widths and the stored entry layout.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W = 32;
    localparam int HIT_W = 16;
    localparam int POS_W = 6;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_TOP    = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_MISSING   = 3'd4,
        ST_TOP       = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HIT_W-1:0] hits;
    } t_entry;

endpackage

// File: rtl/skt_in_if.sv
// ----------------------------------------------------------------------------
// skt_in_if
// Request channel of the sorted key table: operation code and key.
// ----------------------------------------------------------------------------
interface skt_in_if;
    import skt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// File: rtl/skt_out_if.sv
// ----------------------------------------------------------------------------
// skt_out_if
// Result channel of the sorted key table: status, position, key, hit count
// and the last-beat flag.
// ----------------------------------------------------------------------------
interface skt_out_if;
    import skt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] entry_key;
    logic [HIT_W-1:0]        hits;
    logic                    last;

    modport source (output valid, output status, output position, output entry_key,
                    output hits, output last, input ready);
    modport sink   (input valid, input status, input position, input entry_key,
                    input hits, input last, output ready);
endinterface

// File: rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sorted_key_table_with_hit_counts.sv
// ----------------------------------------------------------------------------
// sorted_key_table_with_hit_counts
// Find: binary search over the sorted keys, then a read of the landing slot and the
// result beat. Insert: as find, then the new entry is appended, or the entries at and
// above the slot are moved up one place first. Report: up to TOP_COUNT passes, one beat each.
// One request at a time; the next is taken in the cycle after the last result beat.
// Reset empties the table (count only); the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table_with_hit_counts #(
    parameter int CAPACITY  = 64,
    parameter int TOP_COUNT = 3
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    skt_in_if.sink   i_in,
    skt_out_if.source o_out
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SRCH   = 8'b0000_0010,
        S_SRCH_W = 8'b0000_0100,
        S_LOOK_W = 8'b0000_1000,
        S_SHIFT  = 8'b0001_0000,
        S_WR_NEW = 8'b0010_0000,
        S_SCAN   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    // control
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [AW-1:0]   r_idx, n_idx, r_src, n_src;
    logic            r_more, n_more, r_pend, n_pend;
    logic [CW-1:0]   r_want, n_want, r_n, n_n;
    logic            r_have_prev, n_have_prev, r_bfound, n_bfound;
    logic            r_out_valid, n_out_valid;
    // payload
    t_op             r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [HIT_W-1:0] r_prev_hits, n_prev_hits, r_bhits, n_bhits;
    logic [AW-1:0]   r_prev_idx, n_prev_idx, r_bidx, n_bidx;
    logic [KEY_W-1:0] r_bkey, n_bkey;
    t_status         r_o_status, n_o_status;
    logic [POS_W-1:0] r_o_pos, n_o_pos;
    logic [KEY_W-1:0] r_o_key, n_o_key;
    logic [HIT_W-1:0] r_o_hits, n_o_hits;
    logic            r_o_last, n_o_last;

    // RAM port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_entry          ram_wdata, ram_rdata;

    logic [CW-1:0]   mid_calc, cnt_m1;
    logic            look_hit, key_less, eligible, take;
    logic [HIT_W-1:0] hits_inc;

    skt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);
    assign cnt_m1   = r_count - CW'(1);
    assign key_less = $signed(ram_rdata.key) < $signed(r_key);
    assign look_hit = (r_lo < r_count) && (ram_rdata.key == r_key);
    assign hits_inc = (ram_rdata.hits == HIT_MAX) ? ram_rdata.hits
                                                   : ram_rdata.hits + HIT_W'(1);
    // rank below the previous pick: fewer hits, or same hits at a later index
    assign eligible = !r_have_prev || (ram_rdata.hits < r_prev_hits) ||
                      ((ram_rdata.hits == r_prev_hits) && (r_src > r_prev_idx));
    assign take     = eligible && (!r_bfound || (ram_rdata.hits > r_bhits));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_src       = r_src;
        n_more      = r_more;
        n_pend      = r_pend;
        n_want      = r_want;
        n_n         = r_n;
        n_have_prev = r_have_prev;
        n_bfound    = r_bfound;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_key       = r_key;
        n_prev_hits = r_prev_hits;
        n_prev_idx  = r_prev_idx;
        n_bhits     = r_bhits;
        n_bidx      = r_bidx;
        n_bkey      = r_bkey;
        n_o_status  = r_o_status;
        n_o_pos     = r_o_pos;
        n_o_key     = r_o_key;
        n_o_hits    = r_o_hits;
        n_o_last    = r_o_last;
        ram_we      = 1'b0;
        ram_waddr   = r_lo[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.op)
                        OP_INSERT, OP_FIND: begin
                            n_op    = t_op'(i_in.op);
                            n_key   = i_in.key;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_SRCH;
                        end
                        OP_TOP: begin
                            n_op = OP_TOP;
                            if (r_count == '0) begin
                                n_o_status  = ST_EMPTY;
                                n_o_pos     = '0;
                                n_o_key     = '0;
                                n_o_hits    = '0;
                                n_o_last    = 1'b1;
                                n_out_valid = 1'b1;
                                n_state     = S_EMIT;
                            end else begin
                                n_want      = (r_count < TOP_COUNT) ? r_count
                                                                    : CW'(TOP_COUNT);
                                n_n         = '0;
                                n_have_prev = 1'b0;
                                n_idx       = '0;
                                n_more      = 1'b1;
                                n_pend      = 1'b0;
                                n_bfound    = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            // undefined code: drop the beat
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    ram_raddr = mid_calc[AW-1:0];
                    n_mid     = mid_calc;
                    n_state   = S_SRCH_W;
                end else begin
                    ram_raddr = r_lo[AW-1:0];
                    n_state   = S_LOOK_W;
                end
            end
            S_SRCH_W: begin
                if (key_less) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end
            S_LOOK_W: begin
                n_o_key  = r_key;
                n_o_last = 1'b1;
                if (r_op == OP_INSERT) begin
                    if (look_hit) begin
                        n_o_status  = ST_DUPLICATE;
                        n_o_pos     = POS_W'(r_lo);
                        n_o_hits    = ram_rdata.hits;
                        n_out_valid = 1'b1;
                        n_state     = S_EMIT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_o_status  = ST_FULL;
                        n_o_pos     = '0;
                        n_o_hits    = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_EMIT;
                    end else if (r_lo == r_count) begin
                        n_state = S_WR_NEW;
                    end else begin
                        n_idx   = cnt_m1[AW-1:0];
                        n_more  = 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else begin
                    if (look_hit) begin
                        ram_we         = 1'b1;
                        ram_wdata.key  = r_key;
                        ram_wdata.hits = hits_inc;
                        n_o_status     = ST_FOUND;
                        n_o_pos        = POS_W'(r_lo);
                        n_o_hits       = hits_inc;
                    end else begin
                        n_o_status = ST_MISSING;
                        n_o_pos    = '0;
                        n_o_hits   = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_SHIFT: begin
                // read entry i while writing entry i+1 from the previous read
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_src + AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_more) begin
                    n_src  = r_idx;
                    n_pend = 1'b1;
                    if (CW'(r_idx) == r_lo) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_WR_NEW;
                    end
                end
            end
            S_WR_NEW: begin
                ram_we         = 1'b1;
                ram_wdata.key  = r_key;
                ram_wdata.hits = '0;
                n_count        = r_count + CW'(1);
                n_o_status     = ST_INSERTED;
                n_o_pos        = POS_W'(r_lo);
                n_o_key        = r_key;
                n_o_hits       = '0;
                n_o_last       = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_EMIT;
            end
            S_SCAN: begin
                if (r_more) begin
                    n_src  = r_idx;
                    n_pend = 1'b1;
                    if ((CW'(r_idx) + CW'(1)) == r_count) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && take) begin
                    n_bfound = 1'b1;
                    n_bidx   = r_src;
                    n_bkey   = ram_rdata.key;
                    n_bhits  = ram_rdata.hits;
                end
                if (!r_more && !r_pend) begin
                    n_o_status  = ST_TOP;
                    n_o_pos     = POS_W'(r_bidx);
                    n_o_key     = r_bkey;
                    n_o_hits    = r_bhits;
                    n_o_last    = (r_n + CW'(1)) == r_want;
                    n_prev_hits = r_bhits;
                    n_prev_idx  = r_bidx;
                    n_have_prev = 1'b1;
                    n_n         = r_n + CW'(1);
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx    = '0;
                        n_more   = 1'b1;
                        n_pend   = 1'b0;
                        n_bfound = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_mid       <= '0;
            r_idx       <= '0;
            r_src       <= '0;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_want      <= '0;
            r_n         <= '0;
            r_have_prev <= 1'b0;
            r_bfound    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_mid       <= n_mid;
            r_idx       <= n_idx;
            r_src       <= n_src;
            r_more      <= n_more;
            r_pend      <= n_pend;
            r_want      <= n_want;
            r_n         <= n_n;
            r_have_prev <= n_have_prev;
            r_bfound    <= n_bfound;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_prev_hits <= n_prev_hits;
        r_prev_idx  <= n_prev_idx;
        r_bhits     <= n_bhits;
        r_bidx      <= n_bidx;
        r_bkey      <= n_bkey;
        r_o_status  <= n_o_status;
        r_o_pos     <= n_o_pos;
        r_o_key     <= n_o_key;
        r_o_hits    <= n_o_hits;
        r_o_last    <= n_o_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_o_status;
    assign o_out.position  = r_o_pos;
    assign o_out.entry_key = r_o_key;
    assign o_out.hits      = r_o_hits;
    assign o_out.last      = r_o_last;

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("request taken while a result beat is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_NEW) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one entry");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) <= r_count))
        else $error("RAM write beyond the filled region");

    a_single_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_TOP)) |-> o_out.last)
        else $error("single-beat result without last flag");

endmodule
